// ----- src/hwpg_pkg.sv -----
// Shared constants, types and helpers for the hue wheel pixel generator.
package hwpg_pkg;

  localparam int POS_W           = 5;
  localparam int ANG_W           = 16;
  localparam int CH_W            = 8;
  localparam int FRAC_SHIFT      = 8;
  localparam int CORDIC_STEPS    = 15;
  localparam int STEPS_PER_STAGE = 5;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;

  typedef logic [ANG_W-1:0] angle_t;
  typedef logic [CH_W-1:0]  chan_t;

  localparam angle_t ANG_HALF = 16'h8000;
  localparam chan_t  CH_FULL  = 8'hff;

  // atan(2^-i) in 1/65536 of a turn
  localparam angle_t ATAN_TURNS [CORDIC_STEPS] = '{
    16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
    16'd41,   16'd20,   16'd10,   16'd5,    16'd3,   16'd1,   16'd1
  };

  // hue arithmetic: 16 fraction bits, range up to 6.0 plus sign
  localparam int HFX_W = 21;
  typedef logic signed [HFX_W-1:0] hue_fx_t;

  localparam hue_fx_t FX_ONE   = 21'sd65536;
  localparam hue_fx_t FX_TWO   = 21'sd131072;
  localparam hue_fx_t FX_THREE = 21'sd196608;
  localparam hue_fx_t FX_FOUR  = 21'sd262144;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } rgba_t;

  // clamp to 0..1.0, scale by 255, round half up
  function automatic chan_t to_channel(hue_fx_t c);
    logic [16:0] cl;
    logic [24:0] sc;
    if (c[HFX_W-1]) begin
      cl = '0;
    end else if (c > FX_ONE) begin
      cl = FX_ONE[16:0];
    end else begin
      cl = c[16:0];
    end
    sc = {cl, 8'b0} - {8'b0, cl} + 25'd32768;
    return sc[23:16];
  endfunction

endpackage

// ----- src/hwpg_prep.sv -----
// Centre offset, circle test and CORDIC start vector for one pixel.
module hwpg_prep #(
  parameter int TILE_SIDE = 32,
  parameter int DW        = 8,
  parameter int CW        = 16
) (
  input  logic [hwpg_pkg::POS_W-1:0] x_pos,
  input  logic [hwpg_pkg::POS_W-1:0] y_pos,
  output logic signed [CW-1:0]       x_o,
  output logic signed [CW-1:0]       y_o,
  output hwpg_pkg::angle_t           ang_o,
  output logic                       inside_o
);
  import hwpg_pkg::*;

  localparam logic signed [DW-1:0] CTR  = DW'(TILE_SIDE - 1);
  localparam logic [2*DW:0]        RAD2 = (2*DW+1)'(TILE_SIDE * TILE_SIDE);

  logic signed [DW-1:0]   dx, dy;
  logic signed [2*DW-1:0] dx2, dy2;
  logic [2*DW:0]          dist2;
  logic signed [CW-1:0]   xe, ye;

  always_comb begin
    // offsets in half pixels
    dx    = $signed({{(DW-POS_W-1){1'b0}}, x_pos, 1'b0}) - CTR;
    dy    = $signed({{(DW-POS_W-1){1'b0}}, y_pos, 1'b0}) - CTR;
    dx2   = dx * dx;
    dy2   = dy * dy;
    dist2 = {1'b0, dx2} + {1'b0, dy2};
    inside_o = (dist2 <= RAD2);

    xe = CW'(dx) <<< FRAC_SHIFT;
    ye = CW'(dy) <<< FRAC_SHIFT;
    // left half plane: rotate by half a turn first
    if (dx[DW-1]) begin
      x_o   = -xe;
      y_o   = -ye;
      ang_o = ANG_HALF;
    end else begin
      x_o   = xe;
      y_o   = ye;
      ang_o = '0;
    end
  end

endmodule

// ----- src/hwpg_cordic_stage.sv -----
// One slice of vectoring CORDIC iterations, starting at step FIRST.
module hwpg_cordic_stage #(
  parameter int CW    = 16,
  parameter int FIRST = 0
) (
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  hwpg_pkg::angle_t     ang_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output hwpg_pkg::angle_t     ang_o
);
  import hwpg_pkg::*;

  always_comb begin
    logic signed [CW-1:0] x, y, xs, ys;
    angle_t a;
    x = x_i;
    y = y_i;
    a = ang_i;
    for (int j = 0; j < STEPS_PER_STAGE; j++) begin
      // arithmetic shift gives floor rounding
      xs = x >>> (FIRST + j);
      ys = y >>> (FIRST + j);
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        a = a + ATAN_TURNS[FIRST + j];
      end else begin
        x = x - ys;
        y = y + xs;
        a = a - ATAN_TURNS[FIRST + j];
      end
    end
    x_o   = x;
    y_o   = y;
    ang_o = a;
  end

endmodule

// ----- src/hwpg_color.sv -----
// Hue rotation and triangle hue-to-RGB mapping.
module hwpg_color (
  input  hwpg_pkg::angle_t ang,
  input  hwpg_pkg::angle_t hue_off,
  input  logic             in_circle,
  output hwpg_pkg::rgba_t  rgba
);
  import hwpg_pkg::*;

  angle_t  h;
  hue_fx_t hx, hp, dr, dg, db, ar, ag, ab;

  always_comb begin
    h  = ang + hue_off;
    hx = {5'b0, h};
    hp = (hx <<< 2) + (hx <<< 1);
    dr = hp - FX_THREE;
    dg = hp - FX_TWO;
    db = hp - FX_FOUR;
    ar = dr[HFX_W-1] ? -dr : dr;
    ag = dg[HFX_W-1] ? -dg : dg;
    ab = db[HFX_W-1] ? -db : db;
    if (in_circle) begin
      rgba.red   = to_channel(ar - FX_ONE);
      rgba.green = to_channel(FX_TWO - ag);
      rgba.blue  = to_channel(FX_TWO - ab);
      rgba.alpha = CH_FULL;
    end else begin
      rgba = '0;
    end
  end

endmodule

// ----- src/hue_wheel_pixel_generator_unit.sv -----
// Hue wheel pixel generator: for each (x, y) of a TILE_SIDE square tile it
// returns the RGBA color of a hue wheel drawn in the inscribed circle, zero
// outside. One pixel is taken per clock while in_stall is low; a pixel's
// color reaches the output after passing the input register, the
// offset/circle register, three CORDIC registers of five iterations each,
// and the color/output register in that order. Backpressure on
// the output only stops the stages behind a full stage, so bubbles collapse
// and the input keeps taking pixels while a result waits. The hue offset
// register acts on pixels in flight and is to be written while idle.
module hue_wheel_pixel_generator_unit #(
  parameter int TILE_SIDE = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [15:0]                cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [hwpg_pkg::POS_W-1:0] in_x_pos,
  input  logic [hwpg_pkg::POS_W-1:0] in_y_pos,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hwpg_pkg::CH_W-1:0]  out_red,
  output logic [hwpg_pkg::CH_W-1:0]  out_green,
  output logic [hwpg_pkg::CH_W-1:0]  out_blue,
  output logic [hwpg_pkg::CH_W-1:0]  out_alpha
);
  import hwpg_pkg::*;

  localparam int LOG_T = $clog2(TILE_SIDE);
  localparam int DW    = ((LOG_T > 6) ? LOG_T : 6) + 2;
  localparam int CW    = LOG_T + FRAC_SHIFT + 3;
  localparam int NST   = CORDIC_STAGES + 3;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] rdy;

  angle_t                  hue_off_r;
  logic [POS_W-1:0]        x_r, y_r;
  logic signed [CW-1:0]    cx_r   [CORDIC_STAGES+1];
  logic signed [CW-1:0]    cy_r   [CORDIC_STAGES+1];
  angle_t                  cang_r [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0]  cin_r;
  logic signed [CW-1:0]    cx_nxt   [CORDIC_STAGES+1];
  logic signed [CW-1:0]    cy_nxt   [CORDIC_STAGES+1];
  angle_t                  cang_nxt [CORDIC_STAGES+1];
  logic                    cin_nxt;
  rgba_t                   rgba_r, rgba_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_off_r <= '0;
    end else if (cfg_wr_en) begin
      hue_off_r <= cfg_wr_data;
    end
  end

  // a stage may load when it is empty or its contents move on
  always_comb begin
    rdy[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      x_r <= in_x_pos;
      y_r <= in_y_pos;
    end
  end

  hwpg_prep #(
    .TILE_SIDE(TILE_SIDE),
    .DW       (DW),
    .CW       (CW)
  ) u_prep (
    .x_pos   (x_r),
    .y_pos   (y_r),
    .x_o     (cx_nxt[0]),
    .y_o     (cy_nxt[0]),
    .ang_o   (cang_nxt[0]),
    .inside_o(cin_nxt)
  );

  always_ff @(posedge clk) begin
    if (rdy[1] && vld_r[0]) begin
      cx_r[0]   <= cx_nxt[0];
      cy_r[0]   <= cy_nxt[0];
      cang_r[0] <= cang_nxt[0];
      cin_r[0]  <= cin_nxt;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    hwpg_cordic_stage #(
      .CW   (CW),
      .FIRST(g * STEPS_PER_STAGE)
    ) u_stage (
      .x_i  (cx_r[g]),
      .y_i  (cy_r[g]),
      .ang_i(cang_r[g]),
      .x_o  (cx_nxt[g+1]),
      .y_o  (cy_nxt[g+1]),
      .ang_o(cang_nxt[g+1])
    );

    always_ff @(posedge clk) begin
      if (rdy[g+2] && vld_r[g+1]) begin
        cx_r[g+1]   <= cx_nxt[g+1];
        cy_r[g+1]   <= cy_nxt[g+1];
        cang_r[g+1] <= cang_nxt[g+1];
        cin_r[g+1]  <= cin_r[g];
      end
    end
  end

  hwpg_color u_color (
    .ang      (cang_r[CORDIC_STAGES]),
    .hue_off  (hue_off_r),
    .in_circle(cin_r[CORDIC_STAGES]),
    .rgba     (rgba_nxt)
  );

  always_ff @(posedge clk) begin
    if (rdy[NST-1] && vld_r[NST-2]) begin
      rgba_r <= rgba_nxt;
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_red   = rgba_r.red;
  assign out_green = rgba_r.green;
  assign out_blue  = rgba_r.blue;
  assign out_alpha = rgba_r.alpha;

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the hue wheel pixel generator unit.
`timescale 1ns / 1ps

module testbench;
  import hwpg_pkg::*;

  localparam int SIDE      = 32;
  localparam int STEPS     = 15;
  localparam int UNIT      = 65536;
  localparam int LATENCY   = 6;
  localparam logic [15:0] HALF_TURN = 16'h8000;
  localparam logic [15:0] ARC_TABLE [STEPS] = '{
    16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
    16'd41,   16'd20,   16'd10,   16'd5,    16'd3,   16'd1,   16'd1
  };

  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } pixel_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } color_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} stall_mode_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [15:0]      cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [POS_W-1:0] in_x_pos = '0;
  logic [POS_W-1:0] in_y_pos = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  chan_t            out_red, out_green, out_blue, out_alpha;

  pixel_t      pixel_q[$];
  color_t      color_q[$];
  logic [15:0] hue_rot = '0;
  int          mismatches = 0;

  hue_wheel_pixel_generator_unit #(.TILE_SIDE(SIDE)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_x_pos   (in_x_pos),
    .in_y_pos   (in_y_pos),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_alpha  (out_alpha)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // vectoring CORDIC on the half-pixel offset, angle in 1/65536 turn
  function automatic logic [15:0] polar_turns(int dx, int dy);
    int vx, vy, sx, sy;
    logic [15:0] ang;
    vx = dx * 256;
    vy = dy * 256;
    ang = '0;
    if (dx < 0) begin
      vx = -vx;
      vy = -vy;
      ang = HALF_TURN;
    end
    for (int i = 0; i < STEPS; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy > 0) begin
        vx = vx + sy;
        vy = vy - sx;
        ang = ang + ARC_TABLE[i];
      end else begin
        vx = vx - sy;
        vy = vy + sx;
        ang = ang - ARC_TABLE[i];
      end
    end
    return ang;
  endfunction

  function automatic chan_t scale_channel(int c);
    logic [31:0] prod;
    if (c < 0) c = 0;
    if (c > UNIT) c = UNIT;
    prod = (c * 255 + 32768) >> 16;
    return prod[CH_W-1:0];
  endfunction

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic color_t wheel_color(logic [POS_W-1:0] col, logic [POS_W-1:0] row,
                                         logic [15:0] offset);
    int dx, dy, hp;
    logic [15:0] hue;
    color_t c;
    dx = 2 * int'(col) - (SIDE - 1);
    dy = 2 * int'(row) - (SIDE - 1);
    c = '0;
    if (dx * dx + dy * dy <= SIDE * SIDE) begin
      hue = polar_turns(dx, dy) + offset;
      hp = int'(hue) * 6;
      c.red   = scale_channel(magnitude(hp - 3 * UNIT) - UNIT);
      c.green = scale_channel(2 * UNIT - magnitude(hp - 2 * UNIT));
      c.blue  = scale_channel(2 * UNIT - magnitude(hp - 4 * UNIT));
      c.alpha = 8'hff;
    end
    return c;
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $time);
  endtask

  task automatic queue_pixel(input int col, input int row);
    pixel_t p;
    p.col = col[POS_W-1:0];
    p.row = row[POS_W-1:0];
    pixel_q.push_back(p);
  endtask

  task automatic queue_random_pixels(input int count);
    int col, row, tmp;
    for (int n = 0; n < count; n++) begin
      col = $urandom_range(0, SIDE - 1);
      row = $urandom_range(0, SIDE - 1);
      // some pixels pinned to the border rows/columns, around the circle edge
      if ($urandom_range(0, 99) < 15) begin
        col = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(SIDE - 2, SIDE - 1);
        if ($urandom_range(0, 1)) begin
          tmp = col;
          col = row;
          row = tmp;
        end
      end
      queue_pixel(col, row);
    end
  endtask

  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid || color_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_hue_rot(input logic [15:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    hue_rot = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // sender: bursts of random length separated by random gaps
  logic   in_took = 1'b0;
  int     burst_left = 1;
  int     gap_left = 0;
  pixel_t next_pixel;

  always @(posedge clk) begin
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      color_q.push_back(wheel_color(in_x_pos, in_y_pos, hue_rot));
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pixel_q.size() != 0) begin
        next_pixel = pixel_q.pop_front();
        in_x_pos <= next_pixel.col;
        in_y_pos <= next_pixel.row;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches mode every so often
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_hold = 0;

  always @(negedge clk) begin
    if (stall_hold == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_hold <= $urandom_range(32, 200);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      STALL_BEAT:  out_stall <= ((stall_hold % 5) < 2);
      default:     out_stall <= 1'b0;
    endcase
  end

  color_t want_color;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (color_q.size() == 0) begin
        note_mismatch("transfer with nothing expected, red", out_red, 0);
      end else begin
        want_color = color_q.pop_front();
        if (out_red !== want_color.red)     note_mismatch("red", out_red, want_color.red);
        if (out_green !== want_color.green) note_mismatch("green", out_green, want_color.green);
        if (out_blue !== want_color.blue)   note_mismatch("blue", out_blue, want_color.blue);
        if (out_alpha !== want_color.alpha) note_mismatch("alpha", out_alpha, want_color.alpha);
      end
    end
  end

  logic [15:0] phase_offsets [8];

  initial begin
    phase_offsets = '{16'h0000, 16'hffff, 16'h8000, 16'h0001,
                      16'h0000, 16'h0000, 16'h0000, 16'h0000};
    for (int p = 4; p < 8; p++) phase_offsets[p] = 16'($urandom_range(0, 16'hffff));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: corners, center quad, axis ends, pixels either side of the rim
    queue_pixel(0, 0);
    queue_pixel(31, 31);
    queue_pixel(0, 31);
    queue_pixel(31, 0);
    queue_pixel(15, 15);
    queue_pixel(16, 16);
    queue_pixel(15, 16);
    queue_pixel(16, 15);
    queue_pixel(31, 15);
    queue_pixel(31, 16);
    queue_pixel(0, 15);
    queue_pixel(0, 16);
    queue_pixel(15, 0);
    queue_pixel(16, 0);
    queue_pixel(15, 31);
    queue_pixel(16, 31);
    queue_pixel(11, 0);
    queue_pixel(12, 0);
    queue_pixel(19, 31);
    queue_pixel(20, 31);
    queue_pixel(4, 4);
    queue_pixel(27, 27);
    wait_idle();

    foreach (phase_offsets[p]) begin
      write_hue_rot(phase_offsets[p]);
      queue_random_pixels(240);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// ----- hue_wheel_pixel_generator_unit.f -----
src/hwpg_pkg.sv
src/hwpg_prep.sv
src/hwpg_cordic_stage.sv
src/hwpg_color.sv
src/hue_wheel_pixel_generator_unit.sv
tb/sv/testbench.sv
